// ----- src/uart_rx_fifo_interrupt_regs_defines.svh -----
`ifndef UART_RX_FIFO_INTERRUPT_REGS_DEFINES_SVH
`define UART_RX_FIFO_INTERRUPT_REGS_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define URX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define URX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/urx_pkg.sv -----
package urx_pkg;

  localparam int unsigned URX_FIFO_DEPTH_DEFAULT = 128;

  localparam logic [8:0]  INT_MASK      = 9'h1ff;
  localparam int unsigned INT_RX_THR    = 0;
  localparam int unsigned INT_TX_DONE   = 1;
  localparam int unsigned INT_RX_FULL   = 4;
  localparam int unsigned CONF0_LOOP    = 14;
  localparam int unsigned CONF0_RX_RST  = 17;

  localparam logic [31:0] CLKDIV_RESET   = 32'h0000_02b6;
  localparam logic [31:0] AUTOBAUD_RESET = 32'h0000_1000;
  localparam logic [23:0] CONF0_RESET    = 24'h00_001c;
  localparam logic [31:0] CONF1_RESET    = 32'h0000_6060;
  localparam logic [31:0] PULSE_VALUE    = 32'h000f_ffff;
  localparam logic [31:0] DATE_VALUE     = 32'h0006_2000;
  localparam logic [31:0] ID_VALUE       = 32'h0000_0500;

  // word index = byte address / 4
  localparam logic [5:0] IDX_FIFO      = 6'd0;
  localparam logic [5:0] IDX_INT_RAW   = 6'd1;
  localparam logic [5:0] IDX_INT_ST    = 6'd2;
  localparam logic [5:0] IDX_INT_ENA   = 6'd3;
  localparam logic [5:0] IDX_INT_CLR   = 6'd4;
  localparam logic [5:0] IDX_CLKDIV    = 6'd5;
  localparam logic [5:0] IDX_AUTOBAUD  = 6'd6;
  localparam logic [5:0] IDX_STATUS    = 6'd7;
  localparam logic [5:0] IDX_CONF0     = 6'd8;
  localparam logic [5:0] IDX_CONF1     = 6'd9;
  localparam logic [5:0] IDX_LOWPULSE  = 6'd10;
  localparam logic [5:0] IDX_HIGHPULSE = 6'd11;
  localparam logic [5:0] IDX_RXD_CNT   = 6'd12;
  localparam logic [5:0] IDX_DATE      = 6'd30;
  localparam logic [5:0] IDX_ID        = 6'd31;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2,
    FUNC_NONE  = 2'd3
  } urx_func_e;

  typedef struct packed {
    urx_func_e   func;
    logic [7:0]  byte_addr;
    logic        word_access;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } urx_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } urx_result_t;

endpackage

// ----- src/urx_ram.sv -----
module urx_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic       byp_q;
  logic [7:0] byp_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  // write to the address being read: hand the new byte through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

// ----- src/urx_core.sv -----
`include "uart_rx_fifo_interrupt_regs_defines.svh"

module urx_core
  import urx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = URX_FIFO_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        process_i,
  input  urx_item_t   item_i,
  output urx_result_t result_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned TW = (PW > 7) ? PW : 7;
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [8:0]    raw_q, raw_d, status_q, status_d, enable_q, enable_d;
  logic [31:0]   clkdiv_q, clkdiv_d, autobaud_q, autobaud_d, conf1_q, conf1_d;
  logic [23:0]   conf0_q, conf0_d;

  logic [PW-1:0] count_q, count_d;
  logic          room;
  logic          ok;
  logic [5:0]    idx;
  logic          push, pop, clear, rx_upd, st_upd;
  logic [7:0]    push_data;
  logic [7:0]    head_data;
  logic [31:0]   wd;

  function automatic logic [PW-1:0] ring_count(logic [PW-1:0] hd, logic [PW-1:0] tl);
    logic [PW:0] diff;
    if (tl >= hd) begin
      diff = {1'b0, tl} - {1'b0, hd};
    end else begin
      diff = {1'b0, tl} + DEPTH_W - {1'b0, hd};
    end
    return diff[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  urx_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (push),
    .waddr_i (tail_q),
    .wdata_i (push_data),
    .raddr_i (head_d),
    .rdata_o (head_data)
  );

  assign count_q = ring_count(head_q, tail_q);
  assign count_d = ring_count(head_d, tail_d);
  assign room    = count_q != LAST_PTR;
  assign ok      = item_i.word_access && (item_i.byte_addr[1:0] == 2'b00);
  assign idx     = item_i.byte_addr[7:2];
  assign wd      = item_i.write_data;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    raw_d      = raw_q;
    status_d   = status_q;
    enable_d   = enable_q;
    clkdiv_d   = clkdiv_q;
    autobaud_d = autobaud_q;
    conf0_d    = conf0_q;
    conf1_d    = conf1_q;
    push       = 1'b0;
    pop        = 1'b0;
    clear      = 1'b0;
    rx_upd     = 1'b0;
    st_upd     = 1'b0;
    push_data  = item_i.rx_byte;
    result_o   = '0;

    if (process_i) begin
      case (item_i.func)
        FUNC_READ: begin
          if (ok) begin
            case (idx)
              IDX_FIFO: begin
                if (count_q != '0) begin
                  pop                = 1'b1;
                  rx_upd             = 1'b1;
                  result_o.read_data = {24'b0, head_data};
                end
              end
              IDX_INT_RAW:   result_o.read_data = {23'b0, raw_q};
              IDX_INT_ST:    result_o.read_data = {23'b0, status_q};
              IDX_INT_ENA:   result_o.read_data = {23'b0, enable_q};
              IDX_CLKDIV:    result_o.read_data = clkdiv_q;
              IDX_AUTOBAUD:  result_o.read_data = autobaud_q;
              IDX_STATUS:    result_o.read_data = 32'(count_q);
              IDX_CONF0:     result_o.read_data = {8'b0, conf0_q};
              IDX_CONF1:     result_o.read_data = conf1_q;
              IDX_LOWPULSE:  result_o.read_data = PULSE_VALUE;
              IDX_HIGHPULSE: result_o.read_data = PULSE_VALUE;
              IDX_DATE:      result_o.read_data = DATE_VALUE;
              IDX_ID:        result_o.read_data = ID_VALUE;
              default:       result_o.read_data = '0;
            endcase
          end
        end
        FUNC_WRITE: begin
          if (ok) begin
            case (idx)
              IDX_FIFO: begin
                if (conf0_q[CONF0_LOOP]) begin
                  // loopback: a push that finds the ring full changes nothing
                  push      = room;
                  rx_upd    = room;
                  push_data = wd[7:0];
                end else begin
                  result_o.tx_valid  = 1'b1;
                  result_o.tx_byte   = wd[7:0];
                  raw_d[INT_TX_DONE] = 1'b1;
                  st_upd             = 1'b1;
                end
              end
              IDX_INT_ENA: begin
                enable_d = wd[8:0];
                st_upd   = 1'b1;
              end
              IDX_INT_CLR: begin
                status_d = status_q & ~wd[8:0];
                st_upd   = 1'b1;
              end
              IDX_CLKDIV:   clkdiv_d   = wd;
              IDX_AUTOBAUD: autobaud_d = wd;
              IDX_CONF0: begin
                conf0_d = wd[23:0];
                if (wd[CONF0_RX_RST]) begin
                  clear  = 1'b1;
                  rx_upd = 1'b1;
                end
              end
              IDX_CONF1:    conf1_d    = wd;
              default: ;
            endcase
          end
        end
        FUNC_RX: begin
          push   = room;
          rx_upd = 1'b1;
        end
        default: ;
      endcase
    end

    if (clear) begin
      head_d = '0;
      tail_d = '0;
    end
    if (pop) begin
      head_d = ring_next(head_q);
    end
    if (push) begin
      tail_d = ring_next(tail_q);
    end

    if (rx_upd) begin
      raw_d[INT_RX_THR]  = TW'(count_d) >= TW'(conf1_q[6:0]);
      raw_d[INT_RX_FULL] = count_d == LAST_PTR;
      st_upd             = 1'b1;
    end
    if (st_upd) begin
      status_d = (status_d | raw_d) & INT_MASK;
    end

    result_o.irq = |(status_d & enable_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      raw_q      <= '0;
      status_q   <= '0;
      enable_q   <= '0;
      clkdiv_q   <= CLKDIV_RESET;
      autobaud_q <= AUTOBAUD_RESET;
      conf0_q    <= CONF0_RESET;
      conf1_q    <= CONF1_RESET;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      raw_q      <= raw_d;
      status_q   <= status_d;
      enable_q   <= enable_d;
      clkdiv_q   <= clkdiv_d;
      autobaud_q <= autobaud_d;
      conf0_q    <= conf0_d;
      conf1_q    <= conf1_d;
    end
  end

  `URX_ASSERT(a_ptr_range, (head_q <= LAST_PTR) && (tail_q <= LAST_PTR), "ring pointer out of range")
  `URX_ASSERT(a_no_pop_empty, pop |-> (count_q != '0), "pop from an empty ring")
  `URX_ASSERT(a_no_push_full, push |=> (count_q != '0) && (count_q == $past(count_q) + PW'(1) || $past(pop) || $past(clear)), "push lost or ring overrun")
  `URX_ASSERT(a_irq_level, process_i |=> ($past(result_o.irq) == |(status_q & enable_q)), "irq does not follow status and enable")
  `URX_ASSERT(a_tx_only_write, result_o.tx_valid |-> (process_i && item_i.func == FUNC_WRITE), "tx without a write")

endmodule

// ----- src/uart_rx_fifo_interrupt_regs.sv -----
// UART register block with a receive ring and interrupt bits. Each input word is a 32-bit
// register read, a register write, one byte from the serial line or a no-op (tuser
// selects which), and each gives exactly one result word with the read value, the irq
// level after it and any byte sent out. A word passes through the input register, then
// the register and ring update into the result register; one word is accepted every
// cycle while the result side keeps taking. The ring is a FIFO_DEPTH-entry memory with a
// registered read port that always holds the byte at the head for a pop to take; the ring
// holds up to FIFO_DEPTH-1 bytes. No clearing pass is needed after reset.
module uart_rx_fifo_interrupt_regs
  import urx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = URX_FIFO_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] byte_addr, [39:8] write_data, [47:40] rx_byte
  input  logic [47:0] s_axis_tdata,
  // [1:0] func, [2] word_access
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data, [32] irq, [40:33] tx_byte, [47:41] zero
  output logic [47:0] m_axis_tdata,
  // [0] tx_valid
  output logic        m_axis_tuser
);

  logic        in_valid_q;
  urx_item_t   in_item_q;
  logic        out_valid_q;
  urx_result_t out_res_q;
  urx_result_t res;
  logic        process;

  assign process       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (process) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.func        <= urx_func_e'(s_axis_tuser[1:0]);
      in_item_q.word_access <= s_axis_tuser[2];
      in_item_q.byte_addr   <= s_axis_tdata[7:0];
      in_item_q.write_data  <= s_axis_tdata[39:8];
      in_item_q.rx_byte     <= s_axis_tdata[47:40];
    end
    if (process) begin
      out_res_q <= res;
    end
  end

  urx_core #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .process_i (process),
    .item_i    (in_item_q),
    .result_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_res_q.tx_byte, out_res_q.irq, out_res_q.read_data};
  assign m_axis_tuser  = out_res_q.tx_valid;

endmodule
